// File: hw/rtl/sopf_pkg.sv
// Package for the second-order low-pass filter.
// Holds widths, register indexes, reset values and the gain set type.
`default_nettype none
package sopf_pkg;

  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned COEF_FRAC_BITS = 16;
  localparam int unsigned GAIN_BITS      = 18;
  localparam int unsigned REG_IDX_BITS   = 2;

  localparam logic [REG_IDX_BITS-1:0] REG_INPUT_GAIN = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_LAST_GAIN  = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_OLDER_GAIN = 2'd2;

  localparam logic [GAIN_BITS-1:0] INPUT_GAIN_RESET = 18'd65536;
  localparam logic [GAIN_BITS-1:0] LAST_GAIN_RESET  = 18'd0;
  localparam logic [GAIN_BITS-1:0] OLDER_GAIN_RESET = 18'd0;

  typedef struct packed {
    logic [GAIN_BITS-1:0] input_gain;
    logic [GAIN_BITS-1:0] last_gain;
    logic [GAIN_BITS-1:0] older_gain;
  } gains_t;

endpackage
`default_nettype wire

// File: hw/rtl/sopf_in_if.sv
// Input stream channel of the filter: valid/ready with one sample per word.
// Width defaults from sopf_pkg.
`default_nettype none
interface sopf_in_if #(
  parameter int unsigned W = sopf_pkg::SAMPLE_BITS
);
  logic         valid;
  logic         ready;
  logic [W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sopf_out_if.sv
// Output stream channel of the filter: valid/ready with one filtered sample per word.
// Width defaults from sopf_pkg.
`default_nettype none
interface sopf_out_if #(
  parameter int unsigned W = sopf_pkg::SAMPLE_BITS
);
  logic         valid;
  logic         ready;
  logic [W-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink (input valid, input filtered, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sopf_dp.sv
// Filter datapath: three products, rounding, floor shift and saturation, or x passed through until primed.
// Uses sopf_pkg for the gain set type and gain width.
`default_nettype none
module sopf_dp #(
  parameter int unsigned SAMPLE_BITS    = sopf_pkg::SAMPLE_BITS,
  parameter int unsigned COEF_FRAC_BITS = sopf_pkg::COEF_FRAC_BITS
) (
  input  wire logic signed [SAMPLE_BITS-1:0] x,
  input  wire logic signed [SAMPLE_BITS-1:0] prev_out,
  input  wire logic signed [SAMPLE_BITS-1:0] older_out,
  input  wire sopf_pkg::gains_t              gains,
  input  wire logic                          primed,
  output logic signed [SAMPLE_BITS-1:0]      y
);

  localparam int unsigned GW    = sopf_pkg::GAIN_BITS;
  localparam int unsigned ACC_W = GW + SAMPLE_BITS + 3;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS =
    ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  logic signed [GW:0]      g_in;
  logic signed [GW:0]      g_last;
  logic signed [GW:0]      g_older;
  logic signed [ACC_W-1:0] p_in;
  logic signed [ACC_W-1:0] p_last;
  logic signed [ACC_W-1:0] p_older;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] q;

  assign g_in    = {1'b0, gains.input_gain};
  assign g_last  = {1'b0, gains.last_gain};
  assign g_older = {1'b0, gains.older_gain};

  assign p_in    = ACC_W'(g_in) * ACC_W'(x);
  assign p_last  = ACC_W'(g_last) * ACC_W'(prev_out);
  assign p_older = ACC_W'(g_older) * ACC_W'(older_out);

  assign acc = p_in + p_last - p_older + ROUND_BIAS;
  assign q   = acc >>> COEF_FRAC_BITS;

  always_comb begin
    if (!primed) begin
      y = x;
    end else if (q > SAT_MAX) begin
      y = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (q < SAT_MIN) begin
      y = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      y = q[SAMPLE_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/second_order_low_pass_filter.sv
// Second-order low-pass filter, top level: gain registers, history and output register.
// Depends on sopf_pkg, sopf_in_if, sopf_out_if and sopf_dp.
//
//   channel   kind         word
//   samples   in stream    sample   (signed, SAMPLE_BITS)
//   results   out stream   filtered (signed, SAMPLE_BITS)
//   wr_*      write port   wr_index selects gain, wr_data 18 bits
//
// One word a cycle unless results stall; each result is offered in the next cycle.
// The output history feeds straight back into the multiply-add, so the whole
// sum is formed in the cycle the sample is taken.
// Reset loads the default gains and clears history and the priming count.
// samples.ready is high while the output register is empty or being drained.
`default_nettype none
module second_order_low_pass_filter #(
  parameter int unsigned SAMPLE_BITS    = sopf_pkg::SAMPLE_BITS,
  parameter int unsigned COEF_FRAC_BITS = sopf_pkg::COEF_FRAC_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  sopf_in_if.sink                                    samples,
  sopf_out_if.source                                 results,
  input  wire logic                                  wr_en,
  input  wire logic [sopf_pkg::REG_IDX_BITS-1:0]     wr_index,
  input  wire logic [sopf_pkg::GAIN_BITS-1:0]        wr_data
);

  sopf_pkg::gains_t               gains;
  logic signed [SAMPLE_BITS-1:0]  prev_out;
  logic signed [SAMPLE_BITS-1:0]  older_out;
  logic [1:0]                     prime_count;
  logic signed [SAMPLE_BITS-1:0]  filtered;
  logic                           out_valid;
  logic signed [SAMPLE_BITS-1:0]  x;
  logic signed [SAMPLE_BITS-1:0]  y;
  logic                           take;

  assign x             = samples.sample;
  assign samples.ready = !out_valid || results.ready;
  assign take          = samples.valid && samples.ready;

  assign results.valid    = out_valid;
  assign results.filtered = filtered;

  sopf_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .x         (x),
    .prev_out  (prev_out),
    .older_out (older_out),
    .gains     (gains),
    .primed    (prime_count[1]),
    .y         (y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.input_gain <= sopf_pkg::INPUT_GAIN_RESET;
      gains.last_gain  <= sopf_pkg::LAST_GAIN_RESET;
      gains.older_gain <= sopf_pkg::OLDER_GAIN_RESET;
    end else if (wr_en) begin
      case (wr_index)
        sopf_pkg::REG_INPUT_GAIN: gains.input_gain <= wr_data;
        sopf_pkg::REG_LAST_GAIN:  gains.last_gain  <= wr_data;
        sopf_pkg::REG_OLDER_GAIN: gains.older_gain <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_out    <= '0;
      older_out   <= '0;
      prime_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        older_out <= prev_out;
        prev_out  <= y;
        if (!prime_count[1]) begin
          prime_count <= prime_count + 2'd1;
        end
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      filtered <= y;
    end
  end

endmodule
`default_nettype wire

// File: verif/second_order_low_pass_filter_test.sv
// Self-checking bench for the second-order low-pass filter: directed and random sample streams.
// Expected words come from a cycle-free model of the filter held here.
// Depends on sopf_pkg, sopf_in_if, sopf_out_if and second_order_low_pass_filter.
`timescale 1ns / 1ps
module second_order_low_pass_filter_test;

  localparam int unsigned SAMPLE_BITS    = sopf_pkg::SAMPLE_BITS;
  localparam int unsigned COEF_FRAC_BITS = sopf_pkg::COEF_FRAC_BITS;
  localparam int unsigned GAIN_BITS      = sopf_pkg::GAIN_BITS;
  localparam int unsigned REG_IDX_BITS   = sopf_pkg::REG_IDX_BITS;

  localparam logic [REG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam logic [GAIN_BITS-1:0]    GAIN_MAX   = '1;
  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [REG_IDX_BITS-1:0] wr_index;
  logic [GAIN_BITS-1:0] wr_data;

  sopf_in_if  samples ();
  sopf_out_if results ();

  second_order_low_pass_filter dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .results  (results),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #6 clk = ~clk;

  // Filter model state
  logic [GAIN_BITS-1:0] gain_in = sopf_pkg::INPUT_GAIN_RESET;
  logic [GAIN_BITS-1:0] gain_last = sopf_pkg::LAST_GAIN_RESET;
  logic [GAIN_BITS-1:0] gain_older = sopf_pkg::OLDER_GAIN_RESET;
  logic signed [SAMPLE_BITS-1:0] hist_prev = '0;
  logic signed [SAMPLE_BITS-1:0] hist_older = '0;
  logic [1:0] primed = '0;

  logic signed [SAMPLE_BITS-1:0] expected_filtered[$];
  logic signed [SAMPLE_BITS-1:0] want;
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  function automatic logic signed [SAMPLE_BITS-1:0] next_filtered(
      logic signed [SAMPLE_BITS-1:0] x);
    longint acc;
    longint y;
    if (primed < 2) begin
      y = x;
      primed++;
    end else begin
      acc = longint'(gain_in) * longint'(x) + longint'(gain_last) * longint'(hist_prev)
          - longint'(gain_older) * longint'(hist_older);
      acc += longint'(1) << (COEF_FRAC_BITS - 1);
      y = acc >>> COEF_FRAC_BITS;
      if (y > SAMPLE_MAX) y = SAMPLE_MAX;
      if (y < SAMPLE_MIN) y = SAMPLE_MIN;
    end
    hist_older = hist_prev;
    hist_prev = y[SAMPLE_BITS-1:0];
    return y[SAMPLE_BITS-1:0];
  endfunction

  // Receiver side: random back-pressure
  always @(negedge clk) begin
    results.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) begin
      if (expected_filtered.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %0d", $time,
                 $signed(results.filtered));
        errors++;
      end else begin
        want = expected_filtered.pop_front();
        if (results.filtered !== want) begin
          $display("%0t: filtered mismatch, expected %0d, actual %0d", $time, want,
                   $signed(results.filtered));
          errors++;
        end
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      samples.valid <= 1'b0;
      @(negedge clk);
    end
    samples.valid <= 1'b1;
    samples.sample <= s;
    do @(posedge clk); while (!samples.ready);
    expected_filtered.push_back(next_filtered(s));
    @(negedge clk);
  endtask

  task automatic drain_results();
    samples.valid <= 1'b0;
    @(negedge clk);
    while (expected_filtered.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [GAIN_BITS-1:0] d);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= d;
    case (idx)
      sopf_pkg::REG_INPUT_GAIN: gain_in = d;
      sopf_pkg::REG_LAST_GAIN:  gain_last = d;
      sopf_pkg::REG_OLDER_GAIN: gain_older = d;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_gains(input logic [GAIN_BITS-1:0] k1, input logic [GAIN_BITS-1:0] k2,
                           input logic [GAIN_BITS-1:0] k3);
    write_reg(sopf_pkg::REG_INPUT_GAIN, k1);
    write_reg(sopf_pkg::REG_LAST_GAIN, k2);
    write_reg(sopf_pkg::REG_OLDER_GAIN, k3);
    wr_en <= 1'b0;
  endtask

  // First two words pass through, then unity gain
  task automatic test_priming();
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shffff);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
    drain_results();
  endtask

  // Half gain: ties go up; then all gains zero
  task automatic test_rounding();
    set_gains(18'd32768, '0, '0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd3);
    send_sample(-16'sd3);
    drain_results();
    set_gains('0, '0, '0);
    send_sample(16'sh7fff);
    drain_results();
  endtask

  task automatic test_saturation();
    set_gains(GAIN_MAX, '0, '0);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0001);
    drain_results();
    set_gains('0, GAIN_MAX, '0);
    send_sample(16'sh0000);
    send_sample(16'sh0000);
    drain_results();
    set_gains('0, '0, GAIN_MAX);
    send_sample(16'sh0000);
    send_sample(16'sh0000);
    drain_results();
    set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
    send_sample(16'sd12345);
    send_sample(-16'sd12345);
    send_sample(16'sh0000);
    drain_results();
  endtask

  // Writes to the spare index must leave the gains alone
  task automatic test_unused_index();
    write_reg(sopf_pkg::REG_INPUT_GAIN, 18'd40000);
    write_reg(sopf_pkg::REG_LAST_GAIN, 18'd30000);
    write_reg(sopf_pkg::REG_OLDER_GAIN, 18'd20000);
    write_reg(REG_UNUSED, GAIN_MAX);
    wr_en <= 1'b0;
    send_sample(16'sd1000);
    send_sample(-16'sd2000);
    drain_results();
  endtask

  task automatic test_random_stream(input int idle_pct, input int stall, input int count);
    int sent;
    int shape;
    int amp;
    int period;
    int block;
    int k1;
    int k2;
    int k3;
    logic signed [SAMPLE_BITS-1:0] s;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    sent = 0;
    while (sent < count) begin
      drain_results();
      case ($urandom_range(3))
        0, 1: begin
          // unity DC gain, damped low-pass
          k1 = $urandom_range(200, 8000);
          k3 = $urandom_range(40000, 65000);
          k2 = 65536 + k3 - k1;
          set_gains(GAIN_BITS'(k1), GAIN_BITS'(k2), GAIN_BITS'(k3));
        end
        2: set_gains(GAIN_BITS'($urandom_range(0, GAIN_MAX)),
                     GAIN_BITS'($urandom_range(0, GAIN_MAX)),
                     GAIN_BITS'($urandom_range(0, GAIN_MAX)));
        default: set_gains($urandom_range(1) ? GAIN_MAX : '0, $urandom_range(1) ? GAIN_MAX : '0,
                           $urandom_range(1) ? GAIN_MAX : '0);
      endcase
      shape = $urandom_range(3);
      amp = $urandom_range(1, 32767);
      period = $urandom_range(2, 40);
      block = $urandom_range(30, 70);
      for (int i = 0; i < block && sent < count; i++) begin
        case (shape)
          0: s = SAMPLE_BITS'($urandom);
          1: s = SAMPLE_BITS'(((i / period) % 2) ? -amp : amp);
          2: s = $signed(16'($urandom_range(0, 511))) - 16'sd256;
          default: s = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        endcase
        send_sample(s);
        sent++;
      end
    end
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    samples.valid = 1'b0;
    samples.sample = '0;
    results.ready = 1'b0;
    wr_en = 1'b0;
    wr_index = sopf_pkg::REG_INPUT_GAIN;
    wr_data = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_priming();
    test_rounding();
    test_saturation();
    test_unused_index();
    test_random_stream(0, 0, 390);
    test_random_stream(84, 0, 385);
    test_random_stream(0, 84, 385);
    test_random_stream(17, 17, 390);
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/sopf_pkg.sv
hw/rtl/sopf_in_if.sv
hw/rtl/sopf_out_if.sv
hw/rtl/sopf_dp.sv
hw/rtl/second_order_low_pass_filter.sv
verif/second_order_low_pass_filter_test.sv
